>>> hw/rtl/lkcd_pkg.sv
`default_nettype none

package lkcd_pkg;

  localparam int ENTRIES = 48;
  localparam int SLOT_W  = 6;
  localparam int KEY_W   = 41;
  localparam int AGE_W   = 32;
  localparam int DIM_W   = 16;
  localparam int LOOK_W  = 8;

  localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(2);
  localparam logic [AGE_W-1:0] AGE_START = AGE_W'(1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic              live;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              vhave;
    logic              vfree;
    logic [SLOT_W-1:0] victim;
    logic [AGE_W-1:0]  oldest;
  } scan_t;

  // write broadcast from the controller to every cell
  typedef struct packed {
    logic              clr;
    logic              en;
    logic              set_key;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
  } wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/lkcd_cell.sv
`default_nettype none

module lkcd_cell
  import lkcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] idx,
  input  wire logic [KEY_W-1:0]  key_in,
  input  wire wr_t               wr,
  input  wire scan_t             scan_in,
  output scan_t                  scan_out
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [AGE_W-1:0] age;
  scan_t            scan_next;

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && valid && (key == key_in)) begin
      scan_next.hit     = 1'b1;
      scan_next.hit_idx = idx;
    end
    // first free entry wins outright, else oldest stamp, lowest index on a tie
    if (!scan_in.vfree) begin
      if (!valid) begin
        scan_next.victim = idx;
        scan_next.vfree  = 1'b1;
        scan_next.vhave  = 1'b1;
      end else if (!scan_in.vhave || (age < scan_in.oldest)) begin
        scan_next.victim = idx;
        scan_next.oldest = age;
        scan_next.vhave  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
    if (wr.en && (wr.idx == idx)) begin
      age <= wr.age;
      if (wr.set_key) begin
        key <= wr.key;
      end
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.clr) begin
      valid <= 1'b0;
    end else if (wr.en && wr.set_key && (wr.idx == idx)) begin
      valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lru_keyed_cache_directory.sv
// Fully associative key directory with least-recently-used replacement.
// Input channel: op and the key fields are taken at a rising edge where
// start is high and busy is low. op = clear invalidates all entries and
// restarts the age counter at 1; a lookup with width or height of 2 or less
// is rejected and changes nothing. Both answer in the cycle right after accept.
// A valid lookup launches a search token down a row of ENTRIES cells, one
// cell per cycle; each cell folds its entry into the running match and
// oldest-entry result. When the token leaves the last cell the hit entry is
// restamped, or the chosen victim is refilled, and the result follows.
// Busy stays high from accept until the result is registered, and the
// length of the cell chain sets how long a lookup takes.
// A new item may be started in the cycle the previous result is shown.
// Results: done is high for exactly one cycle with rejected, hit, slot and
// evicted; the receiver must take it then, there is no backpressure.
// Reset (rst, synchronous) empties the directory and sets the counter to 1.
`default_nettype none

module lru_keyed_cache_directory
  import lkcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              op,
  input  wire logic [DIM_W-1:0]  key_width,
  input  wire logic [DIM_W-1:0]  key_height,
  input  wire logic [LOOK_W-1:0] key_look,
  input  wire logic              key_has_icon,
  output logic                   done,
  output logic                   rejected,
  output logic                   hit,
  output logic [SLOT_W-1:0]      slot,
  output logic                   evicted
);

  state_t             state, state_next;
  logic               launch, launch_next;
  logic [KEY_W-1:0]   key, key_next;
  logic [AGE_W-1:0]   age_counter, age_counter_next;
  logic               done_next, rejected_next, hit_next, evicted_next;
  logic [SLOT_W-1:0]  slot_next;
  logic               accept;
  wr_t                wr;
  scan_t              chain [ENTRIES+1];

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_SCAN);

  always_comb begin
    chain[0]      = '0;
    chain[0].live = launch;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (SLOT_W'(i)),
      .key_in   (key),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      launch      <= 1'b0;
      done        <= 1'b0;
      age_counter <= AGE_START;
    end else begin
      state       <= state_next;
      launch      <= launch_next;
      done        <= done_next;
      age_counter <= age_counter_next;
    end
    key      <= key_next;
    rejected <= rejected_next;
    hit      <= hit_next;
    slot     <= slot_next;
    evicted  <= evicted_next;
  end

  always_comb begin
    state_next       = state;
    launch_next      = 1'b0;
    key_next         = key;
    age_counter_next = age_counter;
    done_next        = 1'b0;
    rejected_next    = 1'b0;
    hit_next         = 1'b0;
    slot_next        = '0;
    evicted_next     = 1'b0;
    wr               = '0;
    wr.key           = key;
    wr.age           = age_counter;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_CLEAR) begin
            wr.clr           = 1'b1;
            age_counter_next = AGE_START;
            done_next        = 1'b1;
          end else if ((key_width <= MIN_DIM) || (key_height <= MIN_DIM)) begin
            done_next     = 1'b1;
            rejected_next = 1'b1;
          end else begin
            key_next    = {key_has_icon, key_look, key_height, key_width};
            launch_next = 1'b1;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES].live) begin
          wr.en            = 1'b1;
          age_counter_next = age_counter + AGE_W'(1);
          done_next        = 1'b1;
          state_next       = ST_IDLE;
          if (chain[ENTRIES].hit) begin
            wr.idx    = chain[ENTRIES].hit_idx;
            hit_next  = 1'b1;
            slot_next = chain[ENTRIES].hit_idx;
          end else begin
            wr.idx       = chain[ENTRIES].victim;
            wr.set_key   = 1'b1;
            slot_next    = chain[ENTRIES].victim;
            evicted_next = !chain[ENTRIES].vfree;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lkcd_checker.sv
`default_nettype none

module lkcd_checker
  import lkcd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              op,
  input wire logic [DIM_W-1:0]  key_width,
  input wire logic [DIM_W-1:0]  key_height,
  input wire logic              done,
  input wire logic              rejected,
  input wire logic              hit,
  input wire logic [SLOT_W-1:0] slot,
  input wire logic              evicted
);

  // a rejected item reports nothing else
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> !hit && !evicted && (slot == '0))
    else $error("rejected result carries hit, slot or eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted)
    else $error("hit result also flags an eviction");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(slot) < ENTRIES))
    else $error("result slot beyond the directory");

  // a valid lookup starts a search and holds the channel busy
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_LOOKUP) && (key_width > MIN_DIM)
      && (key_height > MIN_DIM) |=> busy && !done)
    else $error("lookup accepted without a search");

  // clear and rejected items answer without a search
  a_quick_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((op == OP_CLEAR) || (key_width <= MIN_DIM)
      || (key_height <= MIN_DIM)) |=> !busy && done)
    else $error("clear or rejected item not answered in the next cycle");

endmodule

bind lru_keyed_cache_directory lkcd_checker u_lkcd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .key_width  (key_width),
  .key_height (key_height),
  .done       (done),
  .rejected   (rejected),
  .hit        (hit),
  .slot       (slot),
  .evicted    (evicted)
);

`default_nettype wire

>>> bench/lru_keyed_cache_directory_tb.sv
module lru_keyed_cache_directory_tb;
  import lkcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 1000;
  localparam int KEY_POOL    = 60;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic              op;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [LOOK_W-1:0] look;
    logic              icon;
  } dir_item_t;

  typedef struct packed {
    logic              rejected;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } dir_result_t;

  localparam int ITEM_W = $bits(dir_item_t);

  logic              clk;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic              op           = OP_LOOKUP;
  logic [DIM_W-1:0]  key_width    = '0;
  logic [DIM_W-1:0]  key_height   = '0;
  logic [LOOK_W-1:0] key_look     = '0;
  logic              key_has_icon = 1'b0;
  logic              busy;
  logic              done;
  logic              rejected;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;

  lru_keyed_cache_directory i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key_width    (key_width),
    .key_height   (key_height),
    .key_look     (key_look),
    .key_has_icon (key_has_icon),
    .done         (done),
    .rejected     (rejected),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow copy of the directory
  logic             dir_valid [ENTRIES];
  logic [KEY_W-1:0] dir_key   [ENTRIES];
  logic [AGE_W-1:0] dir_age   [ENTRIES];
  logic [AGE_W-1:0] age_ctr;

  dir_item_t   item_q[$];
  dir_result_t lookup_q[$];
  dir_item_t   key_pool[KEY_POOL];
  dir_item_t   nxt_item;
  dir_result_t want;
  logic        send_now;

  int n_sent     = 0;
  int n_errors   = 0;
  int n_hits     = 0;
  int n_fills    = 0;
  int n_evicts   = 0;
  int n_rejects  = 0;
  int n_clears   = 0;
  int stall_cycles = 0;

  function automatic void clear_directory();
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_age[i]   = '0;
    end
    age_ctr = AGE_START;
  endfunction

  function automatic dir_result_t predict_directory(dir_item_t it);
    dir_result_t      res;
    logic [KEY_W-1:0] key;
    int               match_idx;
    int               victim_idx;
    logic             free_found;
    logic [AGE_W-1:0] oldest;
    res        = '0;
    match_idx  = -1;
    victim_idx = -1;
    free_found = 1'b0;
    oldest     = '0;
    key        = {it.icon, it.look, it.h, it.w};
    if (it.op == OP_CLEAR) begin
      clear_directory();
      n_clears++;
      return res;
    end
    if (it.w <= MIN_DIM || it.h <= MIN_DIM) begin
      res.rejected = 1'b1;
      n_rejects++;
      return res;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_idx < 0 && dir_valid[i] && dir_key[i] == key) match_idx = i;
    end
    if (match_idx >= 0) begin
      dir_age[match_idx] = age_ctr;
      age_ctr            = age_ctr + 1'b1;
      res.hit            = 1'b1;
      res.slot           = match_idx[SLOT_W-1:0];
      n_hits++;
      return res;
    end
    // first free entry wins, else the lowest stamp, lowest index on a tie
    for (int i = 0; i < ENTRIES; i++) begin
      if (!free_found) begin
        if (!dir_valid[i]) begin
          victim_idx = i;
          free_found = 1'b1;
        end else if (victim_idx < 0 || dir_age[i] < oldest) begin
          victim_idx = i;
          oldest     = dir_age[i];
        end
      end
    end
    res.slot    = victim_idx[SLOT_W-1:0];
    res.evicted = dir_valid[victim_idx];
    if (res.evicted) n_evicts++;
    else n_fills++;
    dir_valid[victim_idx] = 1'b1;
    dir_key[victim_idx]   = key;
    dir_age[victim_idx]   = age_ctr;
    age_ctr               = age_ctr + 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    n_errors++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
  endtask

  function automatic dir_item_t make_item(logic o, int w, int h, int lk, int ic);
    dir_item_t it;
    it.op   = o;
    it.w    = w[DIM_W-1:0];
    it.h    = h[DIM_W-1:0];
    it.look = lk[LOOK_W-1:0];
    it.icon = ic[0];
    return it;
  endfunction

  // driver: predicts each item at the edge it is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) lookup_q.push_back(predict_directory({op, key_width, key_height,
                                                               key_look, key_has_icon}));
      if (!start || !busy) begin
        // no idling in the middle stretch of the run
        send_now = item_q.size() != 0 &&
                   ((n_sent >= 400 && n_sent < 600) || $urandom_range(99) >= 13);
        if (send_now) begin
          nxt_item = item_q.pop_front();
          n_sent++;
          start <= 1'b1;
        end else begin
          nxt_item = ITEM_W'({$urandom, $urandom});
          start <= 1'b0;
        end
        op           <= nxt_item.op;
        key_width    <= nxt_item.w;
        key_height   <= nxt_item.h;
        key_look     <= nxt_item.look;
        key_has_icon <= nxt_item.icon;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (lookup_q.size() == 0) begin
        report_mismatch("unexpected result, done", 32'(done), 0);
      end else begin
        want = lookup_q.pop_front();
        if (rejected !== want.rejected)
          report_mismatch("rejected", 32'(rejected), 32'(want.rejected));
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
        if (evicted !== want.evicted)
          report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no progress for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int r;
    int pick;
    dir_item_t it;
    clear_directory();

    // directed: smallest legal key, hit, each rejection edge, widest key
    item_q.push_back(make_item(OP_LOOKUP, 3, 3, 0, 0));
    item_q.push_back(make_item(OP_LOOKUP, 3, 3, 0, 0));
    item_q.push_back(make_item(OP_LOOKUP, 2, 100, 7, 1));
    item_q.push_back(make_item(OP_LOOKUP, 100, 2, 7, 1));
    item_q.push_back(make_item(OP_LOOKUP, 0, 0, 0, 0));
    item_q.push_back(make_item(OP_LOOKUP, 1, 65535, 255, 1));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 1, 255, 1));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 65535, 255, 1));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 65535, 255, 0));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 65535, 254, 1));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 3, 128, 0));
    item_q.push_back(make_item(OP_LOOKUP, 3, 3, 0, 0));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 65535, 255, 1));
    item_q.push_back(make_item(OP_CLEAR, 65535, 65535, 255, 1));
    item_q.push_back(make_item(OP_LOOKUP, 65535, 65535, 255, 1));
    item_q.push_back(make_item(OP_LOOKUP, 3, 3, 0, 0));
    item_q.push_back(make_item(OP_CLEAR, 0, 0, 0, 0));

    // a pool a bit larger than the directory keeps it full and replacing
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = make_item(OP_LOOKUP, $urandom_range(65535, 3), $urandom_range(65535, 3),
                              $urandom_range(255), $urandom_range(1));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      r  = $urandom_range(99);
      it = ITEM_W'({$urandom, $urandom});
      it.op = OP_LOOKUP;
      if (r < 2) begin
        it.op = OP_CLEAR;
      end else if (r < 8) begin
        if ($urandom_range(1)) it.w = DIM_W'($urandom_range(2));
        else it.h = DIM_W'($urandom_range(2));
      end else if (r >= 18) begin
        // mostly a small window of the pool for reuse, sometimes any of it
        pick = (n % KEY_POOL + $urandom_range(15)) % KEY_POOL;
        if ($urandom_range(3) == 0) pick = $urandom_range(KEY_POOL - 1);
        it = key_pool[pick];
      end
      item_q.push_back(it);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || start) @(posedge clk);
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    $display("ran %0d items: %0d hits, %0d fills, %0d evictions, %0d rejected, %0d clears",
             n_sent, n_hits, n_fills, n_evicts, n_rejects, n_clears);
    $display("mismatches counted: %0d", n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
